// ===== hw/rtl/uer_pkg.sv =====
package uer_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_EDGE = 2'd0,
        FUNC_TRIG = 2'd1,
        FUNC_READ = 2'd2
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_VALID  = 2'd0,
        STAT_NOECHO = 2'd1,
        STAT_RANGE  = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_MM   = 2'd0,
        CFG_MAX_MM   = 2'd1,
        CFG_MAX_FAIL = 2'd2
    } t_cfg_idx;

    localparam int TIME_W  = 32;
    localparam int DIST_W  = 16;
    localparam int FAIL_W  = 8;
    localparam int CFG_W   = 16;

    localparam logic [DIST_W-1:0] RST_MIN_MM   = 16'd20;
    localparam logic [DIST_W-1:0] RST_MAX_MM   = 16'd4000;
    localparam logic [FAIL_W-1:0] RST_MAX_FAIL = 8'd5;

    // Speed of sound scale: mm = (width * 343 mod 2^32) / 2000
    localparam logic [TIME_W-1:0] SOUND_SCALE = 32'd343;

    // x / 2000 = (x >> 4) / 125, and y / 125 = (y * DIV_MAGIC) >> DIV_SHIFT,
    // exact for every 28-bit y (magic error 7, 7 * 2^28 < 2^35)
    localparam int DIV_PRE    = 4;
    localparam int DIV_Y_W    = TIME_W - DIV_PRE;
    localparam int DIV_M_W    = 29;
    localparam int DIV_SHIFT  = 35;
    localparam logic [DIV_M_W-1:0] DIV_MAGIC = 29'd274877907;
    localparam int DIV_P_W    = DIV_Y_W + DIV_M_W;

    // Read request handed from channel state to the conversion pipe
    typedef struct packed {
        logic              valid;
        logic              ready;
        logic [FAIL_W-1:0] fails;
        logic [TIME_W-1:0] width;
    } t_rd;

endpackage

// ===== hw/rtl/uer_chan_state.sv =====
module uer_chan_state #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  uer_pkg::t_func             i_func,
    input  logic                       i_channel,
    input  logic                       i_level,
    input  logic [uer_pkg::TIME_W-1:0] i_time,
    input  logic [uer_pkg::FAIL_W-1:0] i_max_failures,
    output uer_pkg::t_rd               o_rd
);

    logic [uer_pkg::TIME_W-1:0] r_start [NUM_CHANNELS];
    logic [uer_pkg::TIME_W-1:0] r_width [NUM_CHANNELS];
    logic [uer_pkg::FAIL_W-1:0] r_fail  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]    r_ready;

    logic [NUM_CHANNELS-1:0]    w_hit;
    logic                       w_sel_ready;
    logic [uer_pkg::FAIL_W-1:0] w_sel_fail;
    logic [uer_pkg::TIME_W-1:0] w_sel_width;
    logic [uer_pkg::FAIL_W-1:0] w_fail_inc;
    logic [uer_pkg::FAIL_W-1:0] w_fail_next;

    // Channel decode and read mux; an unused channel reads as never ready
    always_comb begin
        w_sel_ready = 1'b0;
        w_sel_fail  = '0;
        w_sel_width = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            w_hit[i] = (i == int'(i_channel));
            if (w_hit[i]) begin
                w_sel_ready = r_ready[i];
                w_sel_fail  = r_fail[i];
                w_sel_width = r_width[i];
            end
        end
    end

    // Failure count after a read: cleared on a ready read, else bump and wrap
    always_comb begin
        w_fail_inc = w_sel_fail + uer_pkg::FAIL_W'(1);
        if (w_sel_ready) begin
            w_fail_next = '0;
        end else if (w_fail_inc >= i_max_failures) begin
            w_fail_next = '0;
        end else begin
            w_fail_next = w_fail_inc;
        end
    end

    always_comb begin
        o_rd.valid = i_fire && (i_func == uer_pkg::FUNC_READ);
        o_rd.ready = w_sel_ready && (|w_hit);
        o_rd.fails = (|w_hit) ? w_fail_next : '0;
        o_rd.width = w_sel_width;
    end

    // Per-channel state update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_start[i] <= '0;
                r_width[i] <= '0;
                r_fail[i]  <= '0;
            end
            r_ready <= '0;
        end else if (i_fire) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                case (i_func)
                    uer_pkg::FUNC_EDGE: begin
                        if (w_hit[i]) begin
                            if (i_level) begin
                                r_start[i] <= i_time;
                            end else if (r_start[i] != '0) begin
                                r_width[i] <= i_time - r_start[i];
                                r_ready[i] <= 1'b1;
                                r_start[i] <= '0;
                            end
                        end
                    end
                    uer_pkg::FUNC_TRIG: begin
                        r_ready[i] <= 1'b0;
                    end
                    uer_pkg::FUNC_READ: begin
                        if (w_hit[i]) begin
                            r_fail[i] <= w_fail_next;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // A trigger leaves no channel ready
    a_trig_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_func == uer_pkg::FUNC_TRIG) |=> (r_ready == '0))
        else $error("ready flag survived a trigger");

    // A read that finds a completed echo reports and leaves no failures
    a_ready_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd.valid && o_rd.ready |-> (o_rd.fails == '0))
        else $error("ready read kept a failure count");

endmodule

// ===== hw/rtl/uer_convert.sv =====
module uer_convert (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  uer_pkg::t_rd               i_rd,
    input  logic [uer_pkg::DIST_W-1:0] i_min_mm,
    input  logic [uer_pkg::DIST_W-1:0] i_max_mm,
    output logic                       o_valid,
    output logic [uer_pkg::DIST_W-1:0] o_dist,
    output uer_pkg::t_status           o_status,
    output logic [uer_pkg::FAIL_W-1:0] o_fails
);

    logic                       r_s1_valid;
    logic                       r_s1_ready;
    logic [uer_pkg::FAIL_W-1:0] r_s1_fails;
    logic [uer_pkg::TIME_W-1:0] r_s1_width;
    logic                       r_s2_valid;
    logic                       r_s2_ready;
    logic [uer_pkg::FAIL_W-1:0] r_s2_fails;
    logic [uer_pkg::TIME_W-1:0] r_s2_prod;
    logic                       r_o_valid;
    logic [uer_pkg::DIST_W-1:0] r_o_dist;
    uer_pkg::t_status           r_o_status;
    logic [uer_pkg::FAIL_W-1:0] r_o_fails;

    logic [uer_pkg::DIV_Y_W-1:0] w_y;
    logic [uer_pkg::DIV_P_W-1:0] w_qp;
    logic [uer_pkg::DIST_W-1:0]  w_mm;
    logic                        w_in_range;

    // Divide by 2000: drop four bits, then reciprocal multiply by 1/125
    assign w_y  = r_s2_prod[uer_pkg::TIME_W-1:uer_pkg::DIV_PRE];
    assign w_qp = uer_pkg::DIV_P_W'(w_y) * uer_pkg::DIV_P_W'(uer_pkg::DIV_MAGIC);
    assign w_mm = w_qp[uer_pkg::DIV_SHIFT +: uer_pkg::DIST_W];
    assign w_in_range = (w_mm >= i_min_mm) && (w_mm <= i_max_mm);

    // Valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_rd.valid;
            r_s2_valid <= r_s1_valid;
            r_o_valid  <= r_s2_valid;
        end
    end

    // Payload: capture, scale by sound speed, divide and range check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ready <= i_rd.ready;
            r_s1_fails <= i_rd.fails;
            r_s1_width <= i_rd.width;

            r_s2_ready <= r_s1_ready;
            r_s2_fails <= r_s1_fails;
            r_s2_prod  <= uer_pkg::TIME_W'(r_s1_width * uer_pkg::SOUND_SCALE);

            r_o_fails  <= r_s2_fails;
            if (!r_s2_ready) begin
                r_o_status <= uer_pkg::STAT_NOECHO;
                r_o_dist   <= '0;
            end else if (w_in_range) begin
                r_o_status <= uer_pkg::STAT_VALID;
                r_o_dist   <= w_mm;
            end else begin
                r_o_status <= uer_pkg::STAT_RANGE;
                r_o_dist   <= '0;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_dist   = r_o_dist;
    assign o_status = r_o_status;
    assign o_fails  = r_o_fails;

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger_core.sv =====
// Multi-channel echo-pulse ranger. Each input word is an echo edge, a trigger
// of all channels or a read of one channel; only a read returns a word, with
// the distance in mm, a status (valid, no echo since trigger, out of range)
// and the channel failure count. The core accepts one word per clock while
// the output side takes results; a read's result passes through the three
// register stages of the conversion pipe (capture at acceptance, scale by
// the sound speed, reciprocal divide and range check). When a result waits
// at the output the whole pipe holds and input ready drops. Channel state
// updates at acceptance, so a word sees every earlier word's effect.
// Configuration writes are always taken and must occur while the core idles.
module ultrasonic_echo_ranger_core #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] channel, [1] echo_level, [33:2] time_us, [39:34] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] distance_mm, [17:16] status, [25:18] failures, [31:26] zero
    output logic [31:0] m_axis_tdata,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [uer_pkg::DIST_W-1:0] r_min_mm;
    logic [uer_pkg::DIST_W-1:0] r_max_mm;
    logic [uer_pkg::FAIL_W-1:0] r_max_fail;

    logic                       w_en;
    logic                       w_fire;
    uer_pkg::t_rd               w_rd;
    logic                       w_o_valid;
    logic [uer_pkg::DIST_W-1:0] w_dist;
    uer_pkg::t_status           w_status;
    logic [uer_pkg::FAIL_W-1:0] w_fails;

    // Pipe advances whenever the output register is free or being taken
    assign w_en          = !w_o_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_fire        = s_axis_tvalid && w_en;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mm   <= uer_pkg::RST_MIN_MM;
            r_max_mm   <= uer_pkg::RST_MAX_MM;
            r_max_fail <= uer_pkg::RST_MAX_FAIL;
        end else if (i_cfg_valid) begin
            case (uer_pkg::t_cfg_idx'(i_cfg_index))
                uer_pkg::CFG_MIN_MM:   r_min_mm   <= i_cfg_data;
                uer_pkg::CFG_MAX_MM:   r_max_mm   <= i_cfg_data;
                uer_pkg::CFG_MAX_FAIL: r_max_fail <= i_cfg_data[uer_pkg::FAIL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    uer_chan_state #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_chan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_func         (uer_pkg::t_func'(s_axis_tuser)),
        .i_channel      (s_axis_tdata[0]),
        .i_level        (s_axis_tdata[1]),
        .i_time         (s_axis_tdata[33:2]),
        .i_max_failures (r_max_fail),
        .o_rd           (w_rd)
    );

    uer_convert u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_rd     (w_rd),
        .i_min_mm (r_min_mm),
        .i_max_mm (r_max_mm),
        .o_valid  (w_o_valid),
        .o_dist   (w_dist),
        .o_status (w_status),
        .o_fails  (w_fails)
    );

    assign m_axis_tvalid = w_o_valid;
    assign m_axis_tdata  = {6'd0, w_fails, w_status, w_dist};

    // Result words never carry the unused status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_status == uer_pkg::STAT_VALID) ||
                          (w_status == uer_pkg::STAT_NOECHO) ||
                          (w_status == uer_pkg::STAT_RANGE))
        else $error("illegal status on result word");

    // Distance is zero unless the reading is valid
    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status != uer_pkg::STAT_VALID) |-> (w_dist == '0))
        else $error("distance nonzero on failed reading");

    // A completed echo (valid or out of range) resets the failure count
    a_fail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status != uer_pkg::STAT_NOECHO) |-> (w_fails == '0))
        else $error("failure count nonzero after completed echo");

endmodule
